/* hw/rtl/nls_pkg.sv */
package nls_pkg;

   typedef enum logic [1:0] {
      PH_LEAD,
      PH_ZERO,
      PH_DIGITS,
      PH_FRAC
   } phase_type;

   localparam logic [1:0] KIND_INT  = 2'd0;
   localparam logic [1:0] KIND_HEX  = 2'd1;
   localparam logic [1:0] KIND_BIN  = 2'd2;
   localparam logic [1:0] KIND_FRAC = 2'd3;

   localparam logic [1:0] REG_ALLOW_SIGN     = 2'd0;
   localparam logic [1:0] REG_ALLOW_FRACTION = 2'd1;
   localparam logic [1:0] REG_ALLOW_BASE2    = 2'd2;
   localparam logic [1:0] REG_ALLOW_BASE16   = 2'd3;

   typedef struct packed {
      logic allow_sign;
      logic allow_fraction;
      logic allow_base2;
      logic allow_base16;
   } cfg_type;

   typedef struct packed {
      logic      active;
      phase_type phase;
      logic [1:0] kind;
      logic      saw_digit;
   } scan_type;

   typedef struct packed {
      logic       found;
      logic [1:0] kind;
      logic [7:0] length;
      logic       too_long;
   } rsp_type;

endpackage

/* hw/rtl/nls_step.sv */
module nls_step #(
   parameter int MAX_LEN = 255,
   parameter int CNT_W   = 8
) (
   input  logic              start_req,
   input  logic [7:0]        ch,
   input  logic              last,
   input  nls_pkg::cfg_type  cfg,
   input  nls_pkg::scan_type scan,
   input  logic [CNT_W-1:0]  count,
   output nls_pkg::scan_type scan_in,
   output logic [CNT_W-1:0]  count_in,
   output logic              emit,
   output nls_pkg::rsp_type  rsp
);

   localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;

   function automatic logic is_dec(input logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic is_hex(input logic [7:0] c);
      return is_dec(c) || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
   endfunction

   always_comb begin
      nls_pkg::scan_type s;
      logic [CNT_W-1:0]  cnt;
      logic              run_take;
      logic              fin;
      logic              fin_long;
      logic              ok;
      logic [CMP_W-1:0]  cnt_ext;

      s        = scan;
      cnt      = count;
      run_take = 1'b0;
      fin      = 1'b0;
      fin_long = 1'b0;
      ok       = 1'b0;

      if (start_req) begin
         s.active    = 1'b1;
         s.phase     = nls_pkg::PH_LEAD;
         s.kind      = nls_pkg::KIND_INT;
         s.saw_digit = 1'b0;
         cnt         = '0;
         if ((ch == "+") || (ch == "-")) begin
            if (!cfg.allow_sign) begin
               fin = 1'b1;
            end else begin
               cnt = CNT_W'(1);
               if (MAX_LEN <= 1) begin
                  fin      = 1'b1;
                  fin_long = 1'b1;
               end else if (last) begin
                  fin = 1'b1;
               end
            end
         end else begin
            run_take = 1'b1;
         end
      end else if (scan.active) begin
         run_take = 1'b1;
      end

      if (run_take) begin
         case (s.phase)
            nls_pkg::PH_LEAD: begin
               if (ch == "0") begin
                  s.phase = nls_pkg::PH_ZERO; s.saw_digit = 1'b1; ok = 1'b1;
               end else if (is_dec(ch)) begin
                  s.phase = nls_pkg::PH_DIGITS; s.kind = nls_pkg::KIND_INT;
                  s.saw_digit = 1'b1; ok = 1'b1;
               end else if ((ch == ".") && cfg.allow_fraction) begin
                  s.phase = nls_pkg::PH_FRAC; s.kind = nls_pkg::KIND_FRAC; ok = 1'b1;
               end
            end
            nls_pkg::PH_ZERO: begin
               if (((ch == "x") || (ch == "X")) && cfg.allow_base16) begin
                  s.phase = nls_pkg::PH_DIGITS; s.kind = nls_pkg::KIND_HEX;
                  s.saw_digit = 1'b0; ok = 1'b1;
               end else if (((ch == "b") || (ch == "B")) && cfg.allow_base2) begin
                  s.phase = nls_pkg::PH_DIGITS; s.kind = nls_pkg::KIND_BIN;
                  s.saw_digit = 1'b0; ok = 1'b1;
               end else if (is_dec(ch)) begin
                  s.phase = nls_pkg::PH_DIGITS; s.kind = nls_pkg::KIND_INT; ok = 1'b1;
               end else if ((ch == ".") && cfg.allow_fraction) begin
                  s.phase = nls_pkg::PH_FRAC; s.kind = nls_pkg::KIND_FRAC; ok = 1'b1;
               end
            end
            nls_pkg::PH_DIGITS: begin
               if (s.kind == nls_pkg::KIND_BIN) begin
                  if ((ch == "0") || (ch == "1")) begin
                     s.saw_digit = 1'b1; ok = 1'b1;
                  end
               end else if (s.kind == nls_pkg::KIND_HEX) begin
                  if (is_hex(ch)) begin
                     s.saw_digit = 1'b1; ok = 1'b1;
                  end
               end else if (is_dec(ch)) begin
                  s.saw_digit = 1'b1; ok = 1'b1;
               end else if ((ch == ".") && cfg.allow_fraction) begin
                  s.phase = nls_pkg::PH_FRAC; s.kind = nls_pkg::KIND_FRAC; ok = 1'b1;
               end
            end
            nls_pkg::PH_FRAC: begin
               if (is_dec(ch)) begin
                  s.saw_digit = 1'b1; ok = 1'b1;
               end
            end
            default: ok = 1'b0;
         endcase

         if (!ok) begin
            fin = 1'b1;
         end else begin
            // never wraps: the scan closes once the count reaches MAX_LEN
            cnt = cnt + 1'b1;
            if (cnt >= CNT_W'(MAX_LEN)) begin
               fin      = 1'b1;
               fin_long = 1'b1;
            end else if (last) begin
               fin = 1'b1;
            end
         end
      end

      cnt_ext = CMP_W'(cnt);
      if (s.saw_digit) begin
         rsp.found    = 1'b1;
         rsp.kind     = s.kind;
         rsp.length   = (cnt_ext > CMP_W'(255)) ? 8'hff : cnt_ext[7:0];
         rsp.too_long = fin_long;
      end else begin
         rsp = '0;
      end

      if (fin) begin
         s.active = 1'b0;
         s.phase  = nls_pkg::PH_LEAD;
      end

      emit     = fin;
      scan_in  = s;
      count_in = cnt;
   end

endmodule

/* hw/rtl/numeric_literal_scanner_top.sv */
// Channel   Dir  Ports                                        Beat
// req       in   req_valid/req_stall, start_req, ch, last     one source character
// rsp       out  rsp_valid/rsp_stall, found, kind, length,    one scan result
//                too_long
// csr       in   psel/penable/pwrite/paddr/pwdata/prdata      4 one-bit enables
//
// One character per cycle while req_stall is low. Each beat is decoded in a
// single pass against the scan state registers and any result lands in a
// two-deep result queue (output register plus skid) in the same edge.
// req_stall rises only while both queue slots are full. Synchronous
// active-high reset clears scan state, enables and queue.
module numeric_literal_scanner_top #(
   parameter int MAX_LEN = 255
) (
   input  logic        clock,
   input  logic        reset,
   // character stream
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_start_req,
   input  logic [7:0]  req_ch,
   input  logic        req_last,
   // results
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_found,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_length,
   output logic        rsp_too_long,
   // register port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int CNT_W = $clog2(MAX_LEN + 1);

   // ---------------------------------------------------------------- registers
   nls_pkg::cfg_type cfg_ff;

   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (psel && penable && pwrite) begin
         case (paddr[3:2])
            nls_pkg::REG_ALLOW_SIGN:     cfg_ff.allow_sign     <= pwdata[0];
            nls_pkg::REG_ALLOW_FRACTION: cfg_ff.allow_fraction <= pwdata[0];
            nls_pkg::REG_ALLOW_BASE2:    cfg_ff.allow_base2    <= pwdata[0];
            nls_pkg::REG_ALLOW_BASE16:   cfg_ff.allow_base16   <= pwdata[0];
            default:                     cfg_ff                <= cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         nls_pkg::REG_ALLOW_SIGN:     prdata = {31'b0, cfg_ff.allow_sign};
         nls_pkg::REG_ALLOW_FRACTION: prdata = {31'b0, cfg_ff.allow_fraction};
         nls_pkg::REG_ALLOW_BASE2:    prdata = {31'b0, cfg_ff.allow_base2};
         nls_pkg::REG_ALLOW_BASE16:   prdata = {31'b0, cfg_ff.allow_base16};
         default:                     prdata = '0;
      endcase
   end

   // --------------------------------------------------------------- scan state
   nls_pkg::scan_type scan_ff, scan_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              emit;
   nls_pkg::rsp_type  step_rsp;

   nls_step #(
      .MAX_LEN (MAX_LEN),
      .CNT_W   (CNT_W)
   ) u_step (
      .start_req (req_start_req),
      .ch        (req_ch),
      .last      (req_last),
      .cfg       (cfg_ff),
      .scan      (scan_ff),
      .count     (count_ff),
      .scan_in   (scan_in),
      .count_in  (count_in),
      .emit      (emit),
      .rsp       (step_rsp)
   );

   logic accept;
   logic push;
   logic pop;

   // skid slot full means the head is full too; only then hold off characters
   logic skid_valid_ff;
   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;
   assign push      = accept && emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff  <= '{active: 1'b0, phase: nls_pkg::PH_LEAD,
                       kind: nls_pkg::KIND_INT, saw_digit: 1'b0};
         count_ff <= '0;
      end else if (accept) begin
         scan_ff  <= scan_in;
         count_ff <= count_in;
      end
   end

   // ------------------------------------------------------------ result queue
   logic             head_valid_ff;
   nls_pkg::rsp_type head_ff;
   nls_pkg::rsp_type skid_ff;

   assign pop = head_valid_ff && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (pop) begin
         // head drains: skid moves up, a new result refills behind it
         head_valid_ff <= skid_valid_ff || push;
         skid_valid_ff <= skid_valid_ff && push;
      end else if (!head_valid_ff) begin
         head_valid_ff <= push;
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   // payload slots carry no reset
   always_ff @(posedge clock) begin
      if (pop) begin
         head_ff <= skid_valid_ff ? skid_ff : step_rsp;
         if (skid_valid_ff && push) begin
            skid_ff <= step_rsp;
         end
      end else if (!head_valid_ff) begin
         if (push) begin
            head_ff <= step_rsp;
         end
      end else if (push) begin
         skid_ff <= step_rsp;
      end
   end

   assign rsp_valid    = head_valid_ff;
   assign rsp_found    = head_ff.found;
   assign rsp_kind     = head_ff.kind;
   assign rsp_length   = head_ff.length;
   assign rsp_too_long = head_ff.too_long;

   // --------------------------------------------------------------- assertions
   a_skid_needs_head: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> head_valid_ff)
      else $error("skid slot holds a beat while head is empty");

   a_stalled_push_to_skid: assert property (@(posedge clock) disable iff (reset)
      (head_valid_ff && rsp_stall && !skid_valid_ff && push) |=> skid_valid_ff)
      else $error("result lost behind a stalled head");

   a_long_is_found: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_too_long) |-> rsp_found)
      else $error("too_long result without a literal");

   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> (rsp_kind == 2'd0 && rsp_length == 8'd0))
      else $error("not-found result carries nonzero fields");

   a_idle_after_result: assert property (@(posedge clock) disable iff (reset)
      push |=> !scan_ff.active)
      else $error("scan still active after closing");

endmodule
